// File: rtl/i2c_master_transfer_engine_core_defines.svh
// Assertion macros used by the I2C master transfer engine sequencer (i2cm_back).
`ifndef I2C_MASTER_TRANSFER_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_TRANSFER_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/i2cm_pkg.sv
// Types and constants for the I2C master transfer engine.
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_READ      = 2'd1;
  localparam logic [1:0] OP_REG_WRITE = 2'd2;
  localparam logic [1:0] OP_REG_READ  = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CLS_CMD,
    CLS_DATA,
    CLS_TICK,
    CLS_NONE
  } cls_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_WBIT_HI,
    PH_WBIT_LO,
    PH_WACK_HI,
    PH_WACK_LO,
    PH_WAIT,
    PH_RBIT_HI,
    PH_RBIT_LO,
    PH_RACK_HI,
    PH_RACK_LO,
    PH_RESTART,
    PH_STOP_A,
    PH_STOP_B,
    PH_STOP_C
  } phase_t;

  typedef enum logic [1:0] {
    ST_ADDR1,
    ST_REG,
    ST_ADDR2,
    ST_DATA
  } stage_t;

  typedef struct packed {
    cls_t       cls;
    logic [1:0] op;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_request;
    logic       done_res;
    logic       nack_error;
    logic       busy_res;
  } res_t;

endpackage

// File: rtl/i2cm_front.sv
// Front end: classify incoming items and trim the length field.
`timescale 1ns / 1ps
module i2cm_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              kind,
  input  logic [1:0]              op,
  input  logic [6:0]              dev_addr,
  input  logic [7:0]              reg_addr,
  input  logic [15:0]             length,
  input  logic [7:0]              tx_byte,
  input  logic                    sda_in,
  input  logic                    q_ready,
  output logic                    q_push,
  output i2cm_pkg::item_t         q_item,
  output logic [LENGTH_BITS-1:0]  q_length
);
  import i2cm_pkg::*;

  cls_t cls;

  always_comb begin
    unique case (kind)
      KIND_CMD:  cls = CLS_CMD;
      KIND_DATA: cls = CLS_DATA;
      KIND_TICK: cls = CLS_TICK;
      default:   cls = CLS_NONE;
    endcase
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  always_comb begin
    q_item.cls      = cls;
    q_item.op       = op;
    q_item.dev_addr = dev_addr;
    q_item.reg_addr = reg_addr;
    q_item.tx_byte  = tx_byte;
    q_item.sda_in   = sda_in;
  end

  assign q_length = length[LENGTH_BITS-1:0];

endmodule

// File: rtl/i2cm_queue.sv
// Short queue between the front end and the bus sequencer.
`timescale 1ns / 1ps
module i2cm_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);
  import i2cm_pkg::*;

  localparam int unsigned IdxBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]   slots [QUEUE_DEPTH];
  logic [IdxBits-1:0] wr_idx;
  logic [IdxBits-1:0] rd_idx;
  logic [CntBits-1:0] count;

  // Hold off new transfers while in reset.
  assign not_full  = !rst && (count < CntBits'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_data = slots[rd_idx];

  function automatic logic [IdxBits-1:0] bump(input logic [IdxBits-1:0] idx);
    bump = (idx == IdxBits'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= bump(wr_idx);
      end
      if (pop) begin
        rd_idx <= bump(rd_idx);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/i2cm_back.sv
// Back end: bit-level I2C sequencer with a registered result stage.
`timescale 1ns / 1ps
`include "i2c_master_transfer_engine_core_defines.svh"
module i2cm_back #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  i2cm_pkg::item_t        q_item,
  input  logic [LENGTH_BITS-1:0] q_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output i2cm_pkg::res_t         res
);
  import i2cm_pkg::*;

  phase_t                 phase, phase_next;
  stage_t                 stage, stage_next;
  logic [3:0]             bit_count, bit_count_next;
  logic [7:0]             shift_reg, shift_reg_next;
  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;
  logic [LENGTH_BITS-1:0] byte_total, byte_total_next;
  logic [6:0]             target_addr, target_addr_next;
  logic [7:0]             register_index, register_index_next;
  logic [1:0]             transfer_op, transfer_op_next;
  logic [7:0]             pending_byte, pending_byte_next;
  logic                   pending_valid, pending_valid_next;
  logic                   scl_drive, scl_drive_next;
  logic                   sda_drive, sda_drive_next;
  logic                   failed, failed_next;

  logic       rx_valid_c;
  logic [7:0] rx_byte_c;
  logic       done_c;
  logic       do_cont_write;
  logic       do_begin_read;
  logic [7:0] shifted;
  logic [7:0] addr_byte;
  logic [3:0] bit_inc;
  logic [LENGTH_BITS-1:0] count_inc;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    phase_next          = phase;
    stage_next          = stage;
    bit_count_next      = bit_count;
    shift_reg_next      = shift_reg;
    byte_count_next     = byte_count;
    byte_total_next     = byte_total;
    target_addr_next    = target_addr;
    register_index_next = register_index;
    transfer_op_next    = transfer_op;
    pending_byte_next   = pending_byte;
    pending_valid_next  = pending_valid;
    scl_drive_next      = scl_drive;
    sda_drive_next      = sda_drive;
    failed_next         = failed;
    rx_valid_c          = 1'b0;
    rx_byte_c           = '0;
    done_c              = 1'b0;
    do_cont_write       = 1'b0;
    do_begin_read       = 1'b0;
    shifted             = '0;
    bit_inc             = bit_count + 4'd1;
    count_inc           = byte_count + 1'b1;
    addr_byte           = {target_addr, (transfer_op == OP_READ)};

    unique case (q_item.cls)
      CLS_CMD: begin
        if (phase == PH_IDLE) begin
          transfer_op_next    = q_item.op;
          target_addr_next    = q_item.dev_addr;
          register_index_next = q_item.reg_addr;
          byte_total_next     = q_length;
          byte_count_next     = '0;
          pending_valid_next  = 1'b0;
          failed_next         = 1'b0;
          bit_count_next      = '0;
          shift_reg_next      = '0;
          stage_next          = ST_ADDR1;
          scl_drive_next      = 1'b0;
          sda_drive_next      = 1'b0;
          phase_next          = PH_START_A;
        end
      end
      CLS_DATA: begin
        if (phase != PH_IDLE) begin
          pending_byte_next  = q_item.tx_byte;
          pending_valid_next = 1'b1;
          if (phase == PH_WAIT) begin
            pending_valid_next = 1'b0;
            stage_next         = ST_DATA;
            shift_reg_next     = q_item.tx_byte;
            bit_count_next     = '0;
            sda_drive_next     = !q_item.tx_byte[7];
            phase_next         = PH_WBIT_HI;
          end
        end
      end
      CLS_TICK: begin
        unique case (phase)
          PH_START_A: begin
            sda_drive_next = 1'b1;
            phase_next     = PH_START_B;
          end
          PH_START_B: begin
            scl_drive_next = 1'b1;
            if (stage == ST_REG) begin
              stage_next = ST_ADDR2;
              addr_byte  = {target_addr, 1'b1};
            end
            shift_reg_next = addr_byte;
            bit_count_next = '0;
            sda_drive_next = !addr_byte[7];
            phase_next     = PH_WBIT_HI;
          end
          PH_WBIT_HI, PH_WACK_HI, PH_RBIT_HI, PH_RACK_HI: begin
            scl_drive_next = 1'b0;
            unique case (phase)
              PH_WBIT_HI: phase_next = PH_WBIT_LO;
              PH_WACK_HI: phase_next = PH_WACK_LO;
              PH_RBIT_HI: phase_next = PH_RBIT_LO;
              default:    phase_next = PH_RACK_LO;
            endcase
          end
          PH_WBIT_LO: begin
            scl_drive_next = 1'b1;
            shifted        = {shift_reg[6:0], 1'b0};
            shift_reg_next = shifted;
            bit_count_next = bit_inc;
            if (bit_inc < 4'd8) begin
              sda_drive_next = !shifted[7];
              phase_next     = PH_WBIT_HI;
            end else begin
              sda_drive_next = 1'b0;
              phase_next     = PH_WACK_HI;
            end
          end
          PH_WACK_LO: begin
            scl_drive_next = 1'b1;
            if (q_item.sda_in) begin
              failed_next    = 1'b1;
              sda_drive_next = 1'b1;
              phase_next     = PH_STOP_A;
            end else begin
              unique case (stage)
                ST_ADDR1: begin
                  if (transfer_op == OP_WRITE) begin
                    do_cont_write = 1'b1;
                  end else if (transfer_op == OP_READ) begin
                    do_begin_read = 1'b1;
                  end else begin
                    stage_next     = ST_REG;
                    shift_reg_next = register_index;
                    bit_count_next = '0;
                    sda_drive_next = !register_index[7];
                    phase_next     = PH_WBIT_HI;
                  end
                end
                ST_REG: begin
                  if (transfer_op == OP_REG_WRITE) begin
                    do_cont_write = 1'b1;
                  end else begin
                    sda_drive_next = 1'b0;
                    phase_next     = PH_RESTART;
                  end
                end
                ST_ADDR2: do_begin_read = 1'b1;
                default: begin
                  byte_count_next = count_inc;
                  do_cont_write   = 1'b1;
                end
              endcase
            end
          end
          PH_RBIT_LO: begin
            scl_drive_next = 1'b1;
            shifted        = {shift_reg[6:0], q_item.sda_in};
            shift_reg_next = shifted;
            bit_count_next = bit_inc;
            if (bit_inc >= 4'd8) begin
              rx_valid_c      = 1'b1;
              rx_byte_c       = shifted;
              byte_count_next = count_inc;
              sda_drive_next  = (count_inc < byte_total);
              phase_next      = PH_RACK_HI;
            end else begin
              phase_next = PH_RBIT_HI;
            end
          end
          PH_RACK_LO: begin
            scl_drive_next = 1'b1;
            if (byte_count < byte_total) begin
              sda_drive_next = 1'b0;
              shift_reg_next = '0;
              bit_count_next = '0;
              phase_next     = PH_RBIT_HI;
            end else begin
              sda_drive_next = 1'b1;
              phase_next     = PH_STOP_A;
            end
          end
          PH_RESTART: begin
            scl_drive_next = 1'b0;
            phase_next     = PH_START_A;
          end
          PH_STOP_A: begin
            scl_drive_next = 1'b0;
            phase_next     = PH_STOP_B;
          end
          PH_STOP_B: begin
            sda_drive_next = 1'b0;
            phase_next     = PH_STOP_C;
          end
          PH_STOP_C: begin
            done_c             = 1'b1;
            pending_valid_next = 1'b0;
            phase_next         = PH_IDLE;
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // Shared tails of the acknowledge handling.
    if (do_cont_write) begin
      if (byte_count_next >= byte_total) begin
        sda_drive_next = 1'b1;
        phase_next     = PH_STOP_A;
      end else if (pending_valid) begin
        pending_valid_next = 1'b0;
        stage_next         = ST_DATA;
        shift_reg_next     = pending_byte;
        bit_count_next     = '0;
        sda_drive_next     = !pending_byte[7];
        phase_next         = PH_WBIT_HI;
      end else begin
        sda_drive_next = 1'b0;
        phase_next     = PH_WAIT;
      end
    end
    if (do_begin_read) begin
      if (byte_count >= byte_total) begin
        sda_drive_next = 1'b1;
        phase_next     = PH_STOP_A;
      end else begin
        sda_drive_next = 1'b0;
        shift_reg_next = '0;
        bit_count_next = '0;
        stage_next     = ST_DATA;
        phase_next     = PH_RBIT_HI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stage          <= ST_ADDR1;
      bit_count      <= '0;
      shift_reg      <= '0;
      byte_count     <= '0;
      byte_total     <= '0;
      target_addr    <= '0;
      register_index <= '0;
      transfer_op    <= '0;
      pending_byte   <= '0;
      pending_valid  <= 1'b0;
      scl_drive      <= 1'b0;
      sda_drive      <= 1'b0;
      failed         <= 1'b0;
    end else if (q_pop) begin
      phase          <= phase_next;
      stage          <= stage_next;
      bit_count      <= bit_count_next;
      shift_reg      <= shift_reg_next;
      byte_count     <= byte_count_next;
      byte_total     <= byte_total_next;
      target_addr    <= target_addr_next;
      register_index <= register_index_next;
      transfer_op    <= transfer_op_next;
      pending_byte   <= pending_byte_next;
      pending_valid  <= pending_valid_next;
      scl_drive      <= scl_drive_next;
      sda_drive      <= sda_drive_next;
      failed         <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.scl_low    <= scl_drive_next;
      res.sda_low    <= sda_drive_next;
      res.rx_valid   <= rx_valid_c;
      res.rx_byte    <= rx_byte_c;
      res.tx_request <= (phase_next == PH_WAIT);
      res.done_res   <= done_c;
      res.nack_error <= done_c && failed;
      res.busy_res   <= (phase_next != PH_IDLE);
    end
  end

  `I2CM_ASSERT_NEXT(a_wait_holds_on_tick, q_pop && phase == PH_WAIT && q_item.cls == CLS_TICK, phase == PH_WAIT, "tick advanced a transfer waiting for data")
  `I2CM_ASSERT_NOW(a_count_within_total, 1'b1, byte_count <= byte_total, "byte count ran past the byte total")
  `I2CM_ASSERT_NEXT(a_stop_ends_transfer, q_pop && phase == PH_STOP_C && q_item.cls == CLS_TICK, phase == PH_IDLE && out_valid && res.done_res && !res.busy_res, "final stop did not end the transfer")
  `I2CM_ASSERT_NOW(a_stall_blocks_pop, out_valid && !out_ready, !q_pop, "sequencer advanced while a result was stalled")

endmodule

// File: rtl/i2c_master_transfer_engine_core.sv
// Top level of the I2C master transfer engine: front end, queue and sequencer.
// An accepted item is written into the queue; the sequencer pops it and registers its result.
// Throughput: one item per cycle while no result is stalled; each item gives exactly one result in acceptance order.
// The rate is set by the sequencer, which applies one item per cycle to its state registers while no result is stalled.
// Reset (rst, synchronous, active high) empties the queue and the result stage, sets the
// sequencer idle and clears its bus drive registers; no item is accepted while rst is high.
`timescale 1ns / 1ps
module i2c_master_transfer_engine_core #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [1:0]  op,
  input  logic [6:0]  dev_addr,
  input  logic [7:0]  reg_addr,
  input  logic [15:0] length,
  input  logic [7:0]  tx_byte,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_low,
  output logic        sda_low,
  output logic        rx_valid,
  output logic [7:0]  rx_byte,
  output logic        tx_request,
  output logic        done_res,
  output logic        nack_error,
  output logic        busy_res
);
  import i2cm_pkg::*;

  // Each queue entry carries the classified item and the trimmed length.
  localparam int unsigned EntryBits = $bits(item_t) + LENGTH_BITS;

  logic                   q_ready;
  logic                   q_push;
  item_t                  f_item;
  logic [LENGTH_BITS-1:0] f_length;
  logic                   q_valid;
  logic                   q_pop;
  logic [EntryBits-1:0]   q_head;
  item_t                  b_item;
  logic [LENGTH_BITS-1:0] b_length;
  res_t                   res;

  // Front end: decode the kind code and present the transfer to the queue.
  i2cm_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .op       (op),
    .dev_addr (dev_addr),
    .reg_addr (reg_addr),
    .length   (length),
    .tx_byte  (tx_byte),
    .sda_in   (sda_in),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_item   (f_item),
    .q_length (f_length)
  );

  // Queue: lets the front end keep taking items, until it is full, while the sequencer is held by a stalled result.
  i2cm_queue #(
    .WIDTH(EntryBits)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_item, f_length}),
    .not_full  (q_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_data (q_head)
  );

  assign b_item   = q_head[EntryBits-1:LENGTH_BITS];
  assign b_length = q_head[LENGTH_BITS-1:0];

  // Back end: advance the bus sequence by one action and register the result.
  i2cm_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (b_item),
    .q_length  (b_length),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Drop the result group onto the output ports.
  assign scl_low    = res.scl_low;
  assign sda_low    = res.sda_low;
  assign rx_valid   = res.rx_valid;
  assign rx_byte    = res.rx_byte;
  assign tx_request = res.tx_request;
  assign done_res   = res.done_res;
  assign nack_error = res.nack_error;
  assign busy_res   = res.busy_res;

endmodule
